[hw/rtl/wh_pkg.sv]
// Package for the water hydrogen-bond neighbor finder.
// Holds shared widths, payload structs, the controller state type and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wh_pkg;

   localparam int MAX_ATOMS = 4096;
   localparam int MAX_BONDS = 8;

   localparam int IDX_W   = 12;
   localparam int CNT_W   = 13;
   localparam int POS_W   = 21;
   localparam int OH_W    = 16;
   localparam int BC_W    = 4;
   localparam int DSQ_W   = 46;
   localparam int D0SQ_W  = 32;
   localparam int CUT2_W  = 42;
   localparam int NB_W    = $clog2(MAX_BONDS + 1);
   localparam int BIDX_W  = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;
   localparam int ADDR_W  = 5;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [2:0] REG_BOX_X  = 3'd0;
   localparam logic [2:0] REG_BOX_Y  = 3'd1;
   localparam logic [2:0] REG_BOX_Z  = 3'd2;
   localparam logic [2:0] REG_CUTOFF = 3'd3;
   localparam logic [2:0] REG_OH_LEN = 3'd4;

   typedef struct packed {
      logic             opcode;
      logic [IDX_W-1:0] atom_index;
      logic             is_water_oxygen;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] queried_atom;
      logic [IDX_W-1:0] neighbor_atom;
      logic             found;
      logic [BC_W-1:0]  bond_count;
      logic             last;
   } rsp_type;

   // Table entry: water flag on top, then z, y, x.
   typedef struct packed {
      logic             water;
      logic [POS_W-1:0] z;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] x;
   } atom_type;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] z;
   } box_type;

   typedef struct packed {
      logic             done;
      logic [DSQ_W-1:0] dsq;
   } dist_rsp_type;

   typedef struct packed {
      logic done;
      logic pass;
   } ang_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OI_GET,
      ST_SCAN,
      ST_OJ_GET,
      ST_R0_WAIT,
      ST_H_SEL,
      ST_H_GET,
      ST_H_DIST,
      ST_H_ANG,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

[hw/rtl/wh_atom_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wh_atom_ram #(
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[hw/rtl/wh_dist.sv]
// Minimum-image squared distance unit, one axis per cycle.
// Depends on wh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wh_dist import wh_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire atom_type a_pos,
   input  wire atom_type b_pos,
   input  wire box_type  box,
   output dist_rsp_type rsp
);

   logic             busy_ff, done_ff;
   logic [1:0]       axis_ff;
   atom_type         a_ff, b_ff;
   logic [DSQ_W-1:0] acc_ff;

   logic [POS_W-1:0]        from_c, to_c, box_c;
   logic signed [POS_W+1:0] d, mag, res;
   logic signed [2*POS_W+3:0] sq;

   always_comb begin
      case (axis_ff)
         2'd0:    begin from_c = a_ff.x; to_c = b_ff.x; box_c = box.x; end
         2'd1:    begin from_c = a_ff.y; to_c = b_ff.y; box_c = box.y; end
         default: begin from_c = a_ff.z; to_c = b_ff.z; box_c = box.z; end
      endcase
      d   = $signed({2'b00, to_c}) - $signed({2'b00, from_c});
      mag = d[POS_W+1] ? -d : d;
      res = d;
      if ({mag, 1'b0} > {3'b000, box_c}) begin
         res = d[POS_W+1] ? d + $signed({2'b00, box_c}) : d - $signed({2'b00, box_c});
      end
      sq = res * res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         axis_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            axis_ff <= 2'd0;
         end else if (busy_ff) begin
            axis_ff <= axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a_pos;
         b_ff   <= b_pos;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + DSQ_W'(sq);
      end
   end

   assign rsp.done = done_ff;
   assign rsp.dsq  = acc_ff;

endmodule
`default_nettype wire

[hw/rtl/wh_angle.sv]
// Exact squared-cosine angle test with a 48x16 multiplier over six steps.
// Depends on wh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wh_angle import wh_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DSQ_W-1:0]  r0sq,
   input  wire logic [DSQ_W-1:0]  rsq,
   input  wire logic [D0SQ_W-1:0] d0sq,
   output ang_rsp_type            rsp
);

   localparam int OP_W  = 48;
   localparam int ACC_W = 96;

   logic             busy_ff, done_ff, npos_ff;
   logic [2:0]       step_ff;
   logic [OP_W-1:0]  n_ff, r3_ff, d0_ff;
   logic [ACC_W-1:0] lacc_ff, racc_ff;

   logic [OP_W-1:0]  n_c;
   logic [OP_W-1:0]  opa, opb;
   logic [1:0]       dig;
   logic [15:0]      digit;
   logic [63:0]      pp;
   logic [ACC_W-1:0] pp_sh;

   assign n_c = OP_W'(d0sq) + OP_W'(r0sq) - OP_W'(rsq);

   always_comb begin
      if (step_ff < 3'd3) begin
         opa = n_ff;
         opb = n_ff;
         dig = step_ff[1:0];
      end else begin
         opa = r3_ff;
         opb = d0_ff;
         dig = 2'(step_ff - 3'd3);
      end
      digit = 16'(opb >> (16 * dig));
      pp    = opa * digit;
      pp_sh = ACC_W'(pp) << (16 * dig);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff    <= n_c;
         npos_ff <= !n_c[OP_W-1] && (n_c != '0);
         r3_ff   <= OP_W'(r0sq) + OP_W'({r0sq, 1'b0});
         d0_ff   <= OP_W'(d0sq);
         lacc_ff <= '0;
         racc_ff <= '0;
      end else if (busy_ff) begin
         if (step_ff < 3'd3) begin
            lacc_ff <= lacc_ff + pp_sh;
         end else begin
            racc_ff <= racc_ff + pp_sh;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.pass = npos_ff && (lacc_ff > racc_ff);

endmodule
`default_nettype wire

[hw/rtl/water_hbond_neighbor_finder.sv]
// Top level of the water hydrogen-bond neighbor finder.
// Depends on wh_pkg, wh_atom_ram, wh_dist and wh_angle.
//
// Usage: the request channel (req_valid, req_stall, req_data) carries load
// and query items; a transfer happens when req_valid is high and req_stall is
// low. A load writes one atom into the table in the cycle of its transfer
// and produces no result. A query walks the table and returns one or more
// result transfers on rsp_valid, rsp_stall, rsp_data, the last one flagged.
// Configuration (box lengths, cutoff, O-H length) is to be written over the APB
// port only while the block is idle; the block itself does not enforce this.
// pready is always high. A load leaves the block idle for the next request.
// A query of a loaded water oxygen walks the table over the loaded atoms,
// measures the distance to each candidate oxygen, runs the hydrogen tests
// for a candidate within the cutoff and then emits its results. The single
// table read port and shared distance and angle units serialize this work.
// Reset clears the loaded count, the handshake state and the registers to
// their defaults; the table itself is not cleared.
// When the receiver stalls, the result register holds; the next request is
// still accepted once the query has handed its final result to that register.
`timescale 1ns / 1ps
`default_nettype none
module water_hbond_neighbor_finder import wh_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   // Configuration registers.
   logic [POS_W-1:0] box_x_ff, box_y_ff, box_z_ff, cut_ff;
   logic [OH_W-1:0]  oh_ff;
   logic             cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= POS_W'(300000);
         box_y_ff <= POS_W'(300000);
         box_z_ff <= POS_W'(300000);
         cut_ff   <= POS_W'(35000);
         oh_ff    <= OH_W'(9572);
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            REG_BOX_X:  box_x_ff <= pwdata[POS_W-1:0];
            REG_BOX_Y:  box_y_ff <= pwdata[POS_W-1:0];
            REG_BOX_Z:  box_z_ff <= pwdata[POS_W-1:0];
            REG_CUTOFF: cut_ff   <= pwdata[POS_W-1:0];
            REG_OH_LEN: oh_ff    <= pwdata[OH_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_BOX_X:  prdata = 32'(box_x_ff);
         REG_BOX_Y:  prdata = 32'(box_y_ff);
         REG_BOX_Z:  prdata = 32'(box_z_ff);
         REG_CUTOFF: prdata = 32'(cut_ff);
         REG_OH_LEN: prdata = 32'(oh_ff);
         default:    prdata = 32'd0;
      endcase
   end

   // Controller state.
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [NB_W-1:0]  n_ff, n_in;
   logic [NB_W-1:0]  k_ff, k_in;
   logic [1:0]       hsel_ff, hsel_in;
   atom_type         oi_ff, oi_in, oj_ff, oj_in;
   logic [DSQ_W-1:0] r0sq_ff, r0sq_in;
   logic [D0SQ_W-1:0] d0sq_ff;
   logic [CUT2_W-1:0] cut2_ff;
   logic [IDX_W-1:0] found_ff [MAX_BONDS];
   logic             found_wr;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_acc, push;
   logic [IDX_W-1:0] rd_addr;
   atom_type         rd_data;
   logic             wr_en;
   logic [CNT_W-1:0] h_c;
   logic             dist_start, ang_start;
   atom_type         dist_a, dist_b;
   dist_rsp_type     dist_rsp;
   ang_rsp_type      ang_rsp;
   box_type          box;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign wr_en     = req_acc && (req_data.opcode == OP_LOAD)
                      && ({1'b0, req_data.atom_index} < CNT_W'(MAX_ATOMS));
   assign push      = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign box       = '{x: box_x_ff, y: box_y_ff, z: box_z_ff};

   // Hydrogen under test: the queried oxygen's two, then the neighbor's two.
   always_comb begin
      case (hsel_ff)
         2'd0:    h_c = {1'b0, q_ff} + CNT_W'(1);
         2'd1:    h_c = {1'b0, q_ff} + CNT_W'(2);
         2'd2:    h_c = j_ff + CNT_W'(1);
         default: h_c = j_ff + CNT_W'(2);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      count_in     = count_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      hsel_in      = hsel_ff;
      oi_in        = oi_ff;
      oj_in        = oj_ff;
      r0sq_in      = r0sq_ff;
      found_wr     = 1'b0;
      rd_addr      = j_ff[IDX_W-1:0];
      dist_start   = 1'b0;
      dist_a       = oi_ff;
      dist_b       = rd_data;
      ang_start    = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = req_data.atom_index;
            if (req_acc) begin
               if (req_data.opcode == OP_LOAD) begin
                  if (wr_en && ({1'b0, req_data.atom_index} >= count_ff)) begin
                     count_in = {1'b0, req_data.atom_index} + CNT_W'(1);
                  end
               end else begin
                  q_in = req_data.atom_index;
                  n_in = '0;
                  k_in = '0;
                  if ({1'b0, req_data.atom_index} < count_ff) begin
                     state_in = ST_OI_GET;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_OI_GET: begin
            oi_in = rd_data;
            j_in  = '0;
            state_in = rd_data.water ? ST_SCAN : ST_EMIT;
         end
         ST_SCAN: begin
            rd_addr = j_ff[IDX_W-1:0];
            if ((j_ff >= count_ff) || (n_ff == NB_W'(MAX_BONDS))) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_OJ_GET;
            end
         end
         ST_OJ_GET: begin
            oj_in = rd_data;
            if ((j_ff == {1'b0, q_ff}) || !rd_data.water) begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_SCAN;
            end else begin
               dist_start = 1'b1;
               state_in   = ST_R0_WAIT;
            end
         end
         ST_R0_WAIT: begin
            if (dist_rsp.done) begin
               r0sq_in = dist_rsp.dsq;
               if (dist_rsp.dsq > DSQ_W'(cut2_ff)) begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_SCAN;
               end else begin
                  hsel_in  = 2'd0;
                  state_in = ST_H_SEL;
               end
            end
         end
         ST_H_SEL: begin
            rd_addr = h_c[IDX_W-1:0];
            if (h_c >= count_ff) begin
               if (hsel_ff == 2'd3) begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_SCAN;
               end else begin
                  hsel_in = hsel_ff + 2'd1;
               end
            end else begin
               state_in = ST_H_GET;
            end
         end
         ST_H_GET: begin
            dist_start = 1'b1;
            dist_a     = rd_data;
            dist_b     = hsel_ff[1] ? oi_ff : oj_ff;
            state_in   = ST_H_DIST;
         end
         ST_H_DIST: begin
            if (dist_rsp.done) begin
               ang_start = 1'b1;
               state_in  = ST_H_ANG;
            end
         end
         ST_H_ANG: begin
            if (ang_rsp.done) begin
               if (ang_rsp.pass) begin
                  found_wr = 1'b1;
                  n_in     = n_ff + NB_W'(1);
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_SCAN;
               end else if (hsel_ff == 2'd3) begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_SCAN;
               end else begin
                  hsel_in  = hsel_ff + 2'd1;
                  state_in = ST_H_SEL;
               end
            end
         end
         ST_EMIT: begin
            if (push) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.queried_atom = q_ff;
               if (n_ff == '0) begin
                  rsp_data_in.neighbor_atom = '0;
                  rsp_data_in.found         = 1'b0;
                  rsp_data_in.bond_count    = '0;
                  rsp_data_in.last          = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  rsp_data_in.neighbor_atom = found_ff[k_ff[BIDX_W-1:0]];
                  rsp_data_in.found         = 1'b1;
                  rsp_data_in.bond_count    = BC_W'(k_ff + NB_W'(1));
                  rsp_data_in.last          = (k_ff + NB_W'(1) == n_ff);
                  k_in = k_ff + NB_W'(1);
                  if (k_ff + NB_W'(1) == n_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         hsel_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         hsel_ff      <= hsel_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      oi_ff       <= oi_in;
      oj_ff       <= oj_in;
      r0sq_ff     <= r0sq_in;
      rsp_data_ff <= rsp_data_in;
      if (found_wr) begin
         found_ff[n_ff[BIDX_W-1:0]] <= j_ff[IDX_W-1:0];
      end
      // Squared limits are taken per accepted request; configuration must stay stable meanwhile (not enforced here).
      if (req_acc) begin
         d0sq_ff <= oh_ff * oh_ff;
         cut2_ff <= cut_ff * cut_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   wh_atom_ram #(
      .ADDR_BITS(IDX_W),
      .DATA_BITS($bits(atom_type))
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(req_data.atom_index),
      .wr_data({req_data.is_water_oxygen, req_data.pos_z, req_data.pos_y, req_data.pos_x}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   wh_dist u_dist (
      .clock(clock),
      .reset(reset),
      .start(dist_start),
      .a_pos(dist_a),
      .b_pos(dist_b),
      .box  (box),
      .rsp  (dist_rsp)
   );

   wh_angle u_angle (
      .clock(clock),
      .reset(reset),
      .start(ang_start),
      .r0sq (r0sq_ff),
      .rsq  (dist_rsp.dsq),
      .d0sq (d0sq_ff),
      .rsp  (ang_rsp)
   );

endmodule
`default_nettype wire

[hw/rtl/wh_checker.sv]
// Port-level checker for the neighbor finder, bound to the top level.
// Depends on wh_pkg and water_hbond_neighbor_finder.
`timescale 1ns / 1ps
`default_nettype none
module wh_checker import wh_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // An empty result is always the final one and carries no count.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.last && (rsp_data.bond_count == '0) && (rsp_data.neighbor_atom == '0))
      else $error("malformed empty result");

   // Counts of a found neighbor stay in range.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |->
         (rsp_data.bond_count != '0) && (rsp_data.bond_count <= BC_W'(MAX_BONDS)))
      else $error("bond count out of range");

   // A non-final result never reaches the bond limit.
   a_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found && !rsp_data.last |->
         rsp_data.bond_count < BC_W'(MAX_BONDS))
      else $error("result after bond limit");

endmodule

bind water_hbond_neighbor_finder wh_checker u_chk (.*);
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for water_hbond_neighbor_finder: loads water molecules, queries
// hydrogen-bond neighbors and compares each result with an in-bench bond predictor.
// Depends on wh_pkg and the RTL of water_hbond_neighbor_finder.
`timescale 1ns / 1ps
module testbench;
   import wh_pkg::*;

   localparam int WATCH_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   water_hbond_neighbor_finder u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block: atom table, loaded count and register settings.
   atom_type tbl[MAX_ATOMS];
   int       loaded = 0;
   longint   box_len[3] = '{300000, 300000, 300000};
   longint   cut_len = 35000;
   longint   oh_len = 9572;

   req_type  atom_jobs[$];      // items waiting for the driver
   rsp_type  pending_bonds[$];  // results predicted but not yet seen
   int       water_slots[$];    // slots loaded as water oxygens, for queries
   int       next_slot = 0;
   int       mismatches = 0;
   int       results_seen = 0;

   // Minimum image along one axis, folded at most once.
   function automatic longint image_delta(longint box, longint from, longint to);
      longint d, mag;
      d = to - from;
      mag = (d < 0) ? -d : d;
      if (2 * mag > box) begin
         return (d < 0) ? box + d : d - box;
      end
      return d;
   endfunction

   function automatic longint sep_sq(atom_type a, atom_type b);
      longint dx, dy, dz;
      dx = image_delta(box_len[0], a.x, b.x);
      dy = image_delta(box_len[1], a.y, b.y);
      dz = image_delta(box_len[2], a.z, b.z);
      return dx * dx + dy * dy + dz * dz;
   endfunction

   // Squared law-of-cosines test: N > 0 and N^2 > 3 * R0^2 * d0^2, exact in 128 bits.
   function automatic bit cone_ok(longint r0sq, longint rsq);
      longint     d0sq, n;
      bit [127:0] lhs, rhs;
      d0sq = oh_len * oh_len;
      n = d0sq + r0sq - rsq;
      if (n <= 0) begin
         return 1'b0;
      end
      lhs = n;
      lhs = lhs * lhs;
      rhs = r0sq * 3;
      rhs = rhs * d0sq;
      return lhs > rhs;
   endfunction

   // A hydrogen slot at or beyond the loaded count gives no direction.
   function automatic bit hydrogen_ok(int h, atom_type oxy, longint r0sq);
      if (h >= loaded) begin
         return 1'b0;
      end
      return cone_ok(r0sq, sep_sq(tbl[h], oxy));
   endfunction

   function automatic void predict_bonds(int qi);
      int       hits[$];
      atom_type oi, oj;
      longint   r0sq;
      rsp_type  r;
      if (qi < loaded && tbl[qi].water) begin
         oi = tbl[qi];
         for (int j = 0; j < loaded && hits.size() < MAX_BONDS; j++) begin
            oj = tbl[j];
            if (j == qi || !oj.water) continue;
            r0sq = sep_sq(oi, oj);
            if (r0sq > cut_len * cut_len) continue;
            if (hydrogen_ok(qi + 1, oj, r0sq) || hydrogen_ok(qi + 2, oj, r0sq) ||
                hydrogen_ok(j + 1, oi, r0sq) || hydrogen_ok(j + 2, oi, r0sq)) begin
               hits = {hits, j};
            end
         end
      end
      if (hits.size() == 0) begin
         r = '{queried_atom: IDX_W'(qi), neighbor_atom: '0, found: 1'b0, bond_count: '0,
               last: 1'b1};
         pending_bonds = {pending_bonds, r};
      end
      for (int k = 0; k < hits.size(); k++) begin
         r.queried_atom  = IDX_W'(qi);
         r.neighbor_atom = IDX_W'(hits[k]);
         r.found         = 1'b1;
         r.bond_count    = BC_W'(k + 1);
         r.last          = (k == hits.size() - 1);
         pending_bonds = {pending_bonds, r};
      end
   endfunction

   // Accepted requests update the shadow table or produce predictions.
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
      if (!reset && req_valid && !req_stall) begin
         if (req_data.opcode == OP_LOAD) begin
            tbl[req_data.atom_index] = '{water: req_data.is_water_oxygen, z: req_data.pos_z,
                                         y: req_data.pos_y, x: req_data.pos_x};
            if (req_data.atom_index + 1 > loaded) begin
               loaded = req_data.atom_index + 1;
            end
         end else begin
            predict_bonds(req_data.atom_index);
         end
      end
   end

   // Driver: holds a payload until its transfer, then waits a drawn gap before the next.
   int sender_gap = 0;
   bit sender_burst = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_fire) begin
            // Transfer still pending; payload stays put.
         end else if (sender_gap > 0) begin
            sender_gap--;
            req_valid <= 1'b0;
         end else if (atom_jobs.size() > 0) begin
            req_data <= atom_jobs.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 11) == 0) sender_burst = !sender_burst;
            sender_gap = sender_burst ? 0 : $urandom_range(0, 19);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall: a drawn wait per result, plus one long hold-off while the sender
   // still has plenty queued, so that the block backs up and stalls its request side.
   int  receiver_wait = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  receiver_burst = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && results_seen >= 15 && atom_jobs.size() >= 8) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_fire) begin
            if ($urandom_range(0, 11) == 0) receiver_burst = !receiver_burst;
            receiver_wait = receiver_burst ? 0 : $urandom_range(0, 19);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (receiver_wait > 0) begin
            receiver_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Checker: every result transfer must match the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_bonds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: queried %0d neighbor %0d found %0d count %0d last %0d",
                        rsp_data.queried_atom, rsp_data.neighbor_atom, rsp_data.found,
                        rsp_data.bond_count, rsp_data.last);
            end
         end else begin
            want = pending_bonds.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result mismatch: expected q %0d n %0d f %0d c %0d l %0d, got q %0d n %0d f %0d c %0d l %0d",
                           want.queried_atom, want.neighbor_atom, want.found,
                           want.bond_count, want.last,
                           rsp_data.queried_atom, rsp_data.neighbor_atom, rsp_data.found,
                           rsp_data.bond_count, rsp_data.last);
               end
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("water_hbond_neighbor_finder verification failed");
         $finish;
      end
   end

   // Stimulus helpers.
   task automatic push_load(int slot, bit water, longint x, longint y, longint z);
      req_type r;
      r.opcode          = OP_LOAD;
      r.atom_index      = IDX_W'(slot);
      r.is_water_oxygen = water;
      r.pos_x           = x[POS_W-1:0];
      r.pos_y           = y[POS_W-1:0];
      r.pos_z           = z[POS_W-1:0];
      atom_jobs = {atom_jobs, r};
   endtask

   task automatic push_query(int slot);
      req_type r;
      r = '0;
      r.opcode     = OP_QUERY;
      r.atom_index = IDX_W'(slot);
      atom_jobs = {atom_jobs, r};
   endtask

   // One molecule: oxygen then its two hydrogens in the next slots.
   task automatic add_water(longint x, longint y, longint z,
                            longint ax, longint ay, longint az,
                            longint bx, longint by, longint bz);
      water_slots = {water_slots, next_slot};
      push_load(next_slot, 1'b1, x, y, z);
      push_load(next_slot + 1, 1'b0, x + ax, y + ay, z + az);
      push_load(next_slot + 2, 1'b0, x + bx, y + by, z + bz);
      next_slot += 3;
   endtask

   function automatic longint jitter(int span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic csr_write(logic [2:0] code, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {code, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (code)
         REG_BOX_X:  box_len[0] = value[POS_W-1:0];
         REG_BOX_Y:  box_len[1] = value[POS_W-1:0];
         REG_BOX_Z:  box_len[2] = value[POS_W-1:0];
         REG_CUTOFF: cut_len = value[POS_W-1:0];
         REG_OH_LEN: oh_len = value[OH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(longint bx, longint by, longint bz, longint cut, longint oh);
      csr_write(REG_BOX_X, 32'(bx));
      csr_write(REG_BOX_Y, 32'(by));
      csr_write(REG_BOX_Z, 32'(bz));
      csr_write(REG_CUTOFF, 32'(cut));
      csr_write(REG_OH_LEN, 32'(oh));
   endtask

   // The sender pauses here until every predicted result has arrived.
   task automatic drain();
      while (atom_jobs.size() != 0 || req_valid || pending_bonds.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
   endtask

   // Mostly well-formed molecules near one cluster and queries of their oxygens;
   // the rest is full-range noise, stray query indexes and overwrites.
   task automatic random_phase(int count);
      int pick;
      int slot;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45 && next_slot < 3000) begin
            add_water(150000 + jitter(30000), 150000 + jitter(30000), 150000 + jitter(30000),
                      jitter(9572), jitter(9572), jitter(9572),
                      jitter(9572), jitter(9572), jitter(9572));
         end else if (pick < 75 && water_slots.size() > 0) begin
            push_query(water_slots[$urandom_range(0, water_slots.size() - 1)]);
         end else if (pick < 83) begin
            push_query($urandom_range(0, MAX_ATOMS - 1));
         end else if (pick < 90 && next_slot < 3000) begin
            slot = next_slot;
            next_slot++;
            if ($urandom_range(0, 1)) water_slots = {water_slots, slot};
            push_load(slot, water_slots.size() > 0 && water_slots[$] == slot,
                      $urandom_range(0, 2097151), $urandom_range(0, 2097151),
                      $urandom_range(0, 2097151));
         end else if (next_slot > 0) begin
            // Overwrite of a slot already written keeps the table dense.
            slot = $urandom_range(0, next_slot - 1);
            push_load(slot, $urandom_range(0, 1) != 0, 150000 + jitter(30000),
                      150000 + jitter(30000), 150000 + jitter(30000));
         end else begin
            push_query(0);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Defaults written back explicitly, then the directed cases.
      set_geometry(300000, 300000, 300000, 35000, 9572);
      push_query(0);                  // empty table
      push_query(MAX_ATOMS - 1);      // index beyond the loaded count
      // Hydrogen pointing straight at a neighbor 28000 away.
      add_water(100000, 100000, 100000, 9572, 0, 0, -2400, 9265, 0);
      add_water(128000, 100000, 100000, 0, 0, 9572, 0, -9572, 0);
      // A bonded pair that only meets through the periodic boundary.
      add_water(295000, 200000, 200000, 9572, 0, 0, 0, 9572, 0);
      add_water(20000, 200000, 200000, 0, 9572, 0, 0, 0, 9572);
      // Ten coincident oxygens in a row: every pair passes, results saturate.
      for (int k = 0; k < 10; k++) begin
         water_slots = {water_slots, next_slot};
         push_load(next_slot, 1'b1, 50000, 250000, 50000);
         next_slot++;
      end
      // A lone oxygen at the end of the table has no hydrogens loaded after it.
      water_slots = {water_slots, next_slot};
      push_load(next_slot, 1'b1, 50000, 255000, 50000);
      next_slot++;
      push_query(0);
      push_query(3);
      push_query(6);
      push_query(1);                  // a hydrogen, not an oxygen
      push_query(12);
      push_query(next_slot - 1);
      drain();

      random_phase(12);
      drain();

      set_geometry(2097151, 2097151, 2097151, 2097151, 65535);
      random_phase(10);
      drain();

      set_geometry(1, 1, 1, 0, 1);
      random_phase(8);
      drain();

      set_geometry($urandom_range(50000, 400000), $urandom_range(50000, 400000),
                   $urandom_range(50000, 400000), $urandom_range(10000, 60000),
                   $urandom_range(5000, 15000));
      random_phase(8);
      drain();

      if (mismatches == 0) begin
         $display("water_hbond_neighbor_finder verification clean");
      end else begin
         $display("water_hbond_neighbor_finder verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/wh_pkg.sv
hw/rtl/wh_atom_ram.sv
hw/rtl/wh_dist.sv
hw/rtl/wh_angle.sv
hw/rtl/water_hbond_neighbor_finder.sv
hw/rtl/wh_checker.sv
bench/testbench.sv
